>>> hw/rtl/sfd_pkg.sv
// shared types, codes and helper functions for the stomp frame deframer
package sfd_pkg;

    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_CMD    = 4'd1,
        M_HSTART = 4'd2,
        M_NAME   = 4'd3,
        M_VAL    = 4'd4,
        M_VLEN0  = 4'd5,
        M_VLEN1  = 4'd6,
        M_BODYN  = 4'd7,
        M_BODYZ  = 4'd8,
        M_BODYF  = 4'd9
    } t_mode;

    // result kinds
    localparam logic [3:0] K_CMD_BYTE  = 4'd0;
    localparam logic [3:0] K_NAME_BYTE = 4'd1;
    localparam logic [3:0] K_VAL_BYTE  = 4'd2;
    localparam logic [3:0] K_BODY_BYTE = 4'd3;
    localparam logic [3:0] K_CMD_END   = 4'd4;
    localparam logic [3:0] K_HDR_END   = 4'd5;
    localparam logic [3:0] K_HDRS_END  = 4'd6;
    localparam logic [3:0] K_FRAME_END = 4'd7;
    localparam logic [3:0] K_ERROR     = 4'd8;

    // error codes
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_MALFORMED = 3'd1;
    localparam logic [2:0] E_UNTERM    = 3'd2;
    localparam logic [2:0] E_INVALID   = 3'd3;
    localparam logic [2:0] E_BAD_LEN   = 3'd4;
    localparam logic [2:0] E_NO_NUL    = 3'd5;
    localparam logic [2:0] E_FAILED    = 3'd6;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] NAME_LEN = 4'd14;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
        logic [2:0] code;
        logic       last;
    } t_res;

    typedef struct packed {
        logic       vld;
        logic [7:0] ch;
        logic       bad;
        logic       esc;
    } t_unesc;

    // "content-length", one letter per position
    function automatic logic [7:0] len_name_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6f;
            4'd2:    c = 8'h6e;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6e;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2d;
            4'd8:    c = 8'h6c;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6e;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic t_res mk_res(input logic [3:0] kind, input logic [7:0] data,
                                    input logic [2:0] code);
        t_res r;
        r.kind = kind;
        r.data = data;
        r.code = code;
        r.last = 1'b0;
        return r;
    endfunction

    // header escape decoding
    function automatic t_unesc unesc(input logic [7:0] b, input logic esc_open);
        t_unesc u;
        u.vld = 1'b0;
        u.ch  = b;
        u.bad = 1'b0;
        u.esc = 1'b0;
        if (esc_open) begin
            priority case (b)
                CH_BSL: begin u.vld = 1'b1; u.ch = CH_BSL; end
                8'h6e:  begin u.vld = 1'b1; u.ch = CH_LF; end
                8'h72:  begin u.vld = 1'b1; u.ch = CH_CR; end
                8'h63:  begin u.vld = 1'b1; u.ch = CH_COLON; end
                default: u.bad = 1'b1;
            endcase
        end else if (b == CH_BSL) begin
            u.esc = 1'b1;
        end else begin
            u.vld = 1'b1;
        end
        return u;
    endfunction

endpackage

>>> hw/rtl/stomp_frame_deframer.sv
// stomp frame deframer: byte stream in, tagged command/header/body transactions out
// a result enters the output queue as its byte is accepted, then leaves via m_axis
// throughput: one byte per cycle while s_axis_tready is high; a byte that releases
//   a held CR gives two results, which both go into the four-entry output queue
// s_axis_tready drops while fewer than two queue entries are free
// reset (i_rst_n low, synchronous) idles the parser, empties the queue, clears errors
module stomp_frame_deframer #(
    parameter int LENGTH_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    output logic [3:0]  m_axis_tuser,   // [3:0] kind
    output logic        m_axis_tlast    // last result of the input byte
);

    localparam int PW = LENGTH_BITS + 4;

    // parser state
    sfd_pkg::t_mode         r_mode, n_mode;
    logic                   r_held, n_held;
    logic                   r_esc, n_esc;
    logic [1:0]             r_fault, n_fault;
    logic [3:0]             r_pos, n_pos;
    logic                   r_mis, n_mis;
    logic [LENGTH_BITS-1:0] r_acc, n_acc;
    logic                   r_dok, n_dok;
    logic                   r_lpres, n_lpres;
    logic                   r_lvalid, n_lvalid;
    logic [LENGTH_BITS-1:0] r_body, n_body;
    logic                   r_failed, n_failed;

    // results of the current byte
    sfd_pkg::t_res e_res [2];
    logic [1:0]    e_cnt;

    // per pass scratch
    logic          p_end;
    logic          p_byte;
    logic          p_done;
    logic [7:0]    p_ch;
    sfd_pkg::t_unesc p_u;
    logic [PW-1:0] p_prod;
    logic [7:0]    b;

    // output queue
    sfd_pkg::t_res r_q [4];
    logic [1:0]    r_rd, r_wr;
    logic [2:0]    r_cnt;
    logic          acc_in, pop;

    assign b             = s_axis_tdata;
    assign s_axis_tready = (r_cnt <= 3'd2);
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    // one byte of the stream through the parser
    always_comb begin
        n_mode   = r_mode;
        n_held   = r_held;
        n_esc    = r_esc;
        n_fault  = r_fault;
        n_pos    = r_pos;
        n_mis    = r_mis;
        n_acc    = r_acc;
        n_dok    = r_dok;
        n_lpres  = r_lpres;
        n_lvalid = r_lvalid;
        n_body   = r_body;
        n_failed = r_failed;
        e_res[0] = sfd_pkg::mk_res(sfd_pkg::K_CMD_BYTE, 8'h00, sfd_pkg::E_NONE);
        e_res[1] = sfd_pkg::mk_res(sfd_pkg::K_CMD_BYTE, 8'h00, sfd_pkg::E_NONE);
        e_cnt    = 2'd0;
        p_end    = 1'b0;
        p_byte   = 1'b0;
        p_done   = 1'b0;
        p_ch     = 8'h00;
        p_u      = '0;
        p_prod   = '0;

        if (r_failed) begin
            e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_ERROR, 8'h00, sfd_pkg::E_FAILED);
            e_cnt = e_cnt + 2'd1;
        end else if (r_mode == sfd_pkg::M_BODYN) begin
            e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_BODY_BYTE, b, sfd_pkg::E_NONE);
            e_cnt  = e_cnt + 2'd1;
            n_body = r_body - LENGTH_BITS'(1);
            if (n_body == '0) begin
                n_mode = sfd_pkg::M_BODYZ;
            end
        end else if (r_mode == sfd_pkg::M_BODYZ || r_mode == sfd_pkg::M_BODYF) begin
            if (b == sfd_pkg::CH_NUL) begin
                e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_FRAME_END, 8'h00,
                                                  sfd_pkg::E_NONE);
                e_cnt  = e_cnt + 2'd1;
                n_mode = sfd_pkg::M_IDLE;
            end else if (r_mode == sfd_pkg::M_BODYZ) begin
                n_failed = 1'b1;
                n_mode   = sfd_pkg::M_IDLE;
                e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_ERROR, 8'h00,
                                                  sfd_pkg::E_NO_NUL);
                e_cnt = e_cnt + 2'd1;
            end else begin
                e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_BODY_BYTE, b,
                                                  sfd_pkg::E_NONE);
                e_cnt = e_cnt + 2'd1;
            end
        end else begin
            // pass 0 settles a held CR, pass 1 handles the new byte
            for (int p = 0; p < 2; p++) begin
                p_end  = 1'b0;
                p_byte = 1'b0;
                p_ch   = b;
                if (p == 0) begin
                    if (n_held) begin
                        n_held = 1'b0;
                        if (b == sfd_pkg::CH_LF) begin
                            p_end  = 1'b1;
                            p_done = 1'b1;
                        end else begin
                            p_byte = 1'b1;
                            p_ch   = sfd_pkg::CH_CR;
                        end
                    end
                end else if (!p_done) begin
                    if (b == sfd_pkg::CH_LF) begin
                        p_end = 1'b1;
                    end else if (b == sfd_pkg::CH_CR) begin
                        n_held = 1'b1;
                    end else begin
                        p_byte = 1'b1;
                    end
                end

                if (p_byte) begin
                    priority case (n_mode)
                        sfd_pkg::M_IDLE, sfd_pkg::M_CMD: begin
                            n_mode = sfd_pkg::M_CMD;
                            e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_CMD_BYTE, p_ch,
                                                              sfd_pkg::E_NONE);
                            e_cnt = e_cnt + 2'd1;
                        end
                        sfd_pkg::M_HSTART, sfd_pkg::M_NAME: begin
                            if (n_mode == sfd_pkg::M_HSTART) begin
                                n_esc   = 1'b0;
                                n_fault = 2'd0;
                                n_pos   = 4'd0;
                                n_mis   = 1'b0;
                                n_acc   = '0;
                                n_dok   = 1'b0;
                            end
                            if (p_ch == sfd_pkg::CH_COLON) begin
                                if (n_mode == sfd_pkg::M_HSTART) begin
                                    if (n_fault == 2'd0) n_fault = sfd_pkg::E_MALFORMED[1:0];
                                    n_mode = sfd_pkg::M_VAL;
                                end else begin
                                    if (n_esc) begin
                                        if (n_fault == 2'd0) n_fault = sfd_pkg::E_UNTERM[1:0];
                                        n_esc = 1'b0;
                                    end
                                    n_mode = (!n_mis && n_pos == sfd_pkg::NAME_LEN) ?
                                             sfd_pkg::M_VLEN0 : sfd_pkg::M_VAL;
                                    n_dok  = 1'b1;
                                    n_acc  = '0;
                                end
                            end else begin
                                n_mode = sfd_pkg::M_NAME;
                                p_u    = sfd_pkg::unesc(p_ch, n_esc);
                                n_esc  = p_u.esc;
                                if (p_u.bad && n_fault == 2'd0) begin
                                    n_fault = sfd_pkg::E_INVALID[1:0];
                                end
                                if (p_u.vld) begin
                                    e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_NAME_BYTE,
                                                                      p_u.ch,
                                                                      sfd_pkg::E_NONE);
                                    e_cnt = e_cnt + 2'd1;
                                    if (n_pos < sfd_pkg::NAME_LEN &&
                                        p_u.ch == sfd_pkg::len_name_char(n_pos)) begin
                                        n_pos = n_pos + 4'd1;
                                    end else begin
                                        n_mis = 1'b1;
                                    end
                                end
                            end
                        end
                        default: begin
                            p_u   = sfd_pkg::unesc(p_ch, n_esc);
                            n_esc = p_u.esc;
                            if (p_u.bad && n_fault == 2'd0) begin
                                n_fault = sfd_pkg::E_INVALID[1:0];
                            end
                            if (p_u.vld) begin
                                e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_VAL_BYTE,
                                                                  p_u.ch, sfd_pkg::E_NONE);
                                e_cnt = e_cnt + 2'd1;
                                if (n_mode == sfd_pkg::M_VLEN0 ||
                                    n_mode == sfd_pkg::M_VLEN1) begin
                                    if (p_u.ch < sfd_pkg::CH_ZERO ||
                                        p_u.ch > sfd_pkg::CH_NINE) begin
                                        n_dok = 1'b0;
                                    end else begin
                                        n_mode = sfd_pkg::M_VLEN1;
                                        // acc * 10 + digit, overflow shows in the top bits
                                        p_prod = (PW'(n_acc) << 3) + (PW'(n_acc) << 1) +
                                                 PW'(p_u.ch - sfd_pkg::CH_ZERO);
                                        if (n_dok) begin
                                            if (p_prod[PW-1:LENGTH_BITS] != '0) begin
                                                n_dok = 1'b0;
                                            end else begin
                                                n_acc = p_prod[LENGTH_BITS-1:0];
                                            end
                                        end
                                    end
                                end
                            end
                        end
                    endcase
                end

                if (p_end) begin
                    priority case (n_mode)
                        sfd_pkg::M_IDLE: begin
                        end
                        sfd_pkg::M_CMD: begin
                            e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_CMD_END, 8'h00,
                                                              sfd_pkg::E_NONE);
                            e_cnt    = e_cnt + 2'd1;
                            n_lpres  = 1'b0;
                            n_lvalid = 1'b0;
                            n_body   = '0;
                            n_esc    = 1'b0;
                            n_fault  = 2'd0;
                            n_pos    = 4'd0;
                            n_mis    = 1'b0;
                            n_acc    = '0;
                            n_dok    = 1'b0;
                            n_mode   = sfd_pkg::M_HSTART;
                        end
                        sfd_pkg::M_HSTART: begin
                            if (n_lpres && !n_lvalid) begin
                                n_failed = 1'b1;
                                n_mode   = sfd_pkg::M_IDLE;
                                e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_ERROR, 8'h00,
                                                                  sfd_pkg::E_BAD_LEN);
                                e_cnt = e_cnt + 2'd1;
                            end else begin
                                e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_HDRS_END, 8'h00,
                                                                  sfd_pkg::E_NONE);
                                e_cnt = e_cnt + 2'd1;
                                if (!n_lpres) n_mode = sfd_pkg::M_BODYF;
                                else if (n_body != '0) n_mode = sfd_pkg::M_BODYN;
                                else n_mode = sfd_pkg::M_BODYZ;
                            end
                        end
                        sfd_pkg::M_NAME: begin
                            n_failed = 1'b1;
                            n_mode   = sfd_pkg::M_IDLE;
                            e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_ERROR, 8'h00,
                                                              sfd_pkg::E_MALFORMED);
                            e_cnt = e_cnt + 2'd1;
                        end
                        default: begin
                            if (n_esc && n_fault == 2'd0) n_fault = sfd_pkg::E_UNTERM[1:0];
                            if (n_fault != 2'd0) begin
                                n_failed = 1'b1;
                                n_mode   = sfd_pkg::M_IDLE;
                                e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_ERROR, 8'h00,
                                                                  {1'b0, n_fault});
                                e_cnt = e_cnt + 2'd1;
                            end else begin
                                if (n_mode != sfd_pkg::M_VAL) begin
                                    n_lpres  = 1'b1;
                                    n_lvalid = (n_mode == sfd_pkg::M_VLEN1) && n_dok;
                                    n_body   = n_acc;
                                end
                                e_res[e_cnt[0]] = sfd_pkg::mk_res(sfd_pkg::K_HDR_END, 8'h00,
                                                                  sfd_pkg::E_NONE);
                                e_cnt   = e_cnt + 2'd1;
                                n_esc   = 1'b0;
                                n_fault = 2'd0;
                                n_pos   = 4'd0;
                                n_mis   = 1'b0;
                                n_acc   = '0;
                                n_dok   = 1'b0;
                                n_mode  = sfd_pkg::M_HSTART;
                            end
                        end
                    endcase
                end
            end
        end

        // mark the final result of this byte
        if (e_cnt == 2'd1) e_res[0].last = 1'b1;
        if (e_cnt == 2'd2) e_res[1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= sfd_pkg::M_IDLE;
            r_held   <= 1'b0;
            r_esc    <= 1'b0;
            r_fault  <= 2'd0;
            r_pos    <= 4'd0;
            r_mis    <= 1'b0;
            r_acc    <= '0;
            r_dok    <= 1'b0;
            r_lpres  <= 1'b0;
            r_lvalid <= 1'b0;
            r_body   <= '0;
            r_failed <= 1'b0;
        end else if (acc_in) begin
            r_mode   <= n_mode;
            r_held   <= n_held;
            r_esc    <= n_esc;
            r_fault  <= n_fault;
            r_pos    <= n_pos;
            r_mis    <= n_mis;
            r_acc    <= n_acc;
            r_dok    <= n_dok;
            r_lpres  <= n_lpres;
            r_lvalid <= n_lvalid;
            r_body   <= n_body;
            r_failed <= n_failed;
        end
    end

    // output queue: up to two pushes and one pop per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 2'd0;
            r_wr  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_rd  <= r_rd + {1'b0, pop};
            r_wr  <= r_wr + (acc_in ? e_cnt : 2'd0);
            r_cnt <= r_cnt + (acc_in ? {1'b0, e_cnt} : 3'd0) - {2'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in && e_cnt != 2'd0) r_q[r_wr] <= e_res[0];
        if (acc_in && e_cnt == 2'd2) r_q[r_wr + 2'd1] <= e_res[1];
    end

    assign m_axis_tdata = {5'b0, r_q[r_rd].code, r_q[r_rd].data};
    assign m_axis_tuser = r_q[r_rd].kind;
    assign m_axis_tlast = r_q[r_rd].last;

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 3'd4)
        else $error("output queue overflow");
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |-> r_cnt <= 3'd2)
        else $error("byte taken without room for two results");
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |=> r_failed)
        else $error("error state left without reset");
    a_fail_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> r_mode == sfd_pkg::M_IDLE)
        else $error("failed parser not idle");
    a_cr_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_mode != sfd_pkg::M_BODYN && r_mode != sfd_pkg::M_BODYZ &&
                    r_mode != sfd_pkg::M_BODYF))
        else $error("CR held inside a body");
`endif

endmodule
